### rtl/core/compass_edge_convolution_3x3_unit_assert.svh
// assertion macros used by the compass edge convolution top level
`ifndef COMPASS_EDGE_CONVOLUTION_3X3_UNIT_ASSERT_SVH
`define COMPASS_EDGE_CONVOLUTION_3X3_UNIT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define CECU_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define CECU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/cecu_pkg.sv
// shared types, constants and mask table for the compass edge convolution unit
package cecu_pkg;

	localparam int MAX_WIDTH          = 4096;
	localparam int HEIGHT_LIMIT       = 4096;
	localparam int ADDR_W             = $clog2(MAX_WIDTH);
	localparam int DIM_W              = 13;
	localparam int ROW_W              = 13;
	localparam int CH_W               = 8;
	localparam int NUM_CH             = 3;
	localparam int PIX_W              = CH_W * NUM_CH;
	localparam int LINE_W             = 2 * PIX_W;
	localparam int NUM_TAPS           = 9;
	localparam int NUM_MASKS          = 8;
	localparam int COEF_BITS          = 7;
	localparam int KERN_W             = NUM_TAPS * COEF_BITS;
	localparam int CFG_IDX_W          = 2;
	localparam int ROW_WIDTH_RESET    = 640;
	localparam int FRAME_HEIGHT_RESET = 480;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROW_WIDTH,
		REG_FRAME_HEIGHT,
		REG_KERNEL_MODE,
		REG_CUSTOM_KERNEL
	} cfg_reg_t;

	typedef logic [PIX_W-1:0] pix_t;
	typedef pix_t [NUM_TAPS-1:0] win_t;

	typedef struct packed {
		logic [DIM_W-1:0] width;
		logic [DIM_W-1:0] height;
	} geom_t;

	typedef struct packed {
		logic has_out;
		logic top;
		logic bot;
		logic left;
		logic right;
		logic last;
	} pos_t;

	typedef struct packed {
		win_t win;
		logic last;
	} win_word_t;

	// sobel mask rotated s steps around the outer ring, tap k row-major
	function automatic logic signed [2:0] compass_coef(input int s, input int k);
		int ring;
		logic signed [2:0] v;
		case (k)
			0: ring = 0;
			1: ring = 1;
			2: ring = 2;
			5: ring = 3;
			8: ring = 4;
			7: ring = 5;
			6: ring = 6;
			3: ring = 7;
			default: ring = -1;
		endcase
		case ((ring + s) & 7)
			0: v = -3'sd1;
			1: v = 3'sd0;
			2: v = 3'sd1;
			3: v = 3'sd2;
			4: v = 3'sd1;
			5: v = 3'sd0;
			6: v = -3'sd1;
			default: v = -3'sd2;
		endcase
		if (ring < 0) v = 3'sd0;
		return v;
	endfunction

endpackage

### rtl/core/cecu_ram.sv
// generic simple dual-port ram with registered read
module cecu_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		if (re) rdata <= mem_q[raddr];
	end

endmodule

### rtl/core/cecu_window.sv
// raster position counters, line store read-modify-write and 3x3 window
module cecu_window (
	input  logic                clk,
	input  logic                arst_n,
	input  cecu_pkg::geom_t     geom,
	input  logic                restart,
	input  logic                in_valid,
	output logic                in_ready,
	input  cecu_pkg::pix_t      pix,
	output logic                win_valid,
	input  logic                win_ready,
	output cecu_pkg::win_word_t win_word
);
	import cecu_pkg::*;

	logic [ADDR_W-1:0] col_q, col_c;
	logic [ROW_W-1:0]  row_q, row_c;
	logic              wrap, col_end, accept;
	logic [DIM_W-1:0]  wm1, hm1, orow, ocol;
	pos_t              pos;

	logic              s1_v_q, s1_adv;
	pix_t              pix_s1;
	logic [ADDR_W-1:0] addr_s1;
	pos_t              pos_s1;
	logic              fwd_s1;
	logic [LINE_W-1:0] fwd_data_s1;
	logic [LINE_W-1:0] rdata, line_s1, wdata;

	win_t      win_q, win_n, win_m;
	logic      win_v_s2;
	win_word_t win_word_s2;

	// position of this word, restarting when the counts run past the geometry
	always_comb begin
		wrap = ({1'b0, col_q} >= geom.width) ||
			({1'b0, row_q} > ({1'b0, geom.height} + 14'd1));
		col_c = wrap ? '0 : col_q;
		row_c = wrap ? '0 : row_q;
		wm1 = geom.width - 13'd1;
		hm1 = geom.height - 13'd1;
		col_end = ({1'b0, col_c} == wm1);
		if (col_c == '0) begin
			orow = row_c - 13'd2;
			ocol = wm1;
		end else begin
			orow = row_c - 13'd1;
			ocol = {1'b0, col_c} - 13'd1;
		end
		pos.has_out = (row_c >= 13'd2) || ((row_c == 13'd1) && (col_c != '0));
		pos.top = (orow == '0);
		pos.bot = (orow == hm1);
		pos.left = (ocol == '0);
		pos.right = (ocol == wm1);
		pos.last = pos.has_out && pos.bot && pos.right;
	end

	assign s1_adv   = s1_v_q && (!pos_s1.has_out || !win_v_s2 || win_ready);
	assign in_ready = !s1_v_q || s1_adv;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (restart) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (pos.last) begin
				col_q <= '0;
				row_q <= '0;
			end else if (col_end) begin
				col_q <= '0;
				row_q <= row_c + 13'd1;
			end else begin
				col_q <= col_c + 12'd1;
				row_q <= row_c;
			end
		end
	end

	// line entry holds {upper, middle}; forward when the entry was written as it was read
	assign line_s1 = fwd_s1 ? fwd_data_s1 : rdata;
	assign wdata   = {line_s1[PIX_W-1:0], pix_s1};

	cecu_ram #(
		.WIDTH(LINE_W),
		.DEPTH(MAX_WIDTH)
	) u_line_ram (
		.clk  (clk),
		.we   (s1_adv),
		.waddr(addr_s1),
		.wdata(wdata),
		.re   (accept),
		.raddr(col_c),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
		end else if (accept) begin
			s1_v_q <= 1'b1;
		end else if (s1_adv) begin
			s1_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1      <= pix;
			addr_s1     <= col_c;
			pos_s1      <= pos;
			fwd_s1      <= s1_adv && (addr_s1 == col_c);
			fwd_data_s1 <= wdata;
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			win_n[i*3+0] = win_q[i*3+1];
			win_n[i*3+1] = win_q[i*3+2];
		end
		win_n[2] = line_s1[LINE_W-1:PIX_W];
		win_n[5] = line_s1[PIX_W-1:0];
		win_n[8] = pix_s1;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				if ((j == 0 && pos_s1.left) || (j == 2 && pos_s1.right) ||
					(i == 0 && pos_s1.top) || (i == 2 && pos_s1.bot)) begin
					win_m[i*3+j] = '0;
				end else begin
					win_m[i*3+j] = win_n[i*3+j];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (s1_adv) begin
			win_q <= win_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_v_s2 <= 1'b0;
		end else if (s1_adv && pos_s1.has_out) begin
			win_v_s2 <= 1'b1;
		end else if (win_ready) begin
			win_v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && pos_s1.has_out) begin
			win_word_s2.win  <= win_m;
			win_word_s2.last <= pos_s1.last;
		end
	end

	assign win_valid = win_v_s2;
	assign win_word  = win_word_s2;

endmodule

### rtl/core/cecu_filter.sv
// mask products, clamping, summing and divide by eight
module cecu_filter (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          kernel_mode,
	input  logic [cecu_pkg::KERN_W-1:0]   custom_kernel,
	input  logic                          win_valid,
	output logic                          win_ready,
	input  cecu_pkg::win_word_t           win_word,
	output logic                          out_valid,
	input  logic                          out_ready,
	output cecu_pkg::pix_t                out_pix,
	output logic                          out_last
);
	import cecu_pkg::*;

	logic [CH_W-1:0] cmp_c [NUM_CH][NUM_MASKS];
	logic [CH_W-1:0] cust_c [NUM_CH];
	logic [CH_W-1:0] cmp_s3 [NUM_CH][NUM_MASKS];
	logic [CH_W-1:0] cust_s3 [NUM_CH];
	logic            last_s3, s3_v_q, o_v_q, o_ready;
	pix_t            pix_c, pix_q;
	logic            last_q;

	assign o_ready   = !o_v_q || out_ready;
	assign win_ready = !s3_v_q || o_ready;

	always_comb begin
		logic signed [11:0] acc;
		logic signed [19:0] cacc;
		logic [CH_W-1:0] p;
		for (int ch = 0; ch < NUM_CH; ch++) begin
			for (int s = 0; s < NUM_MASKS; s++) begin
				acc = '0;
				for (int k = 0; k < NUM_TAPS; k++) begin
					p = win_word.win[k][ch*CH_W +: CH_W];
					acc = acc + $signed({4'b0, p}) * 12'(compass_coef(s, k));
				end
				if (acc > 12'sd255) cmp_c[ch][s] = 8'd255;
				else if (acc < 12'sd0) cmp_c[ch][s] = '0;
				else cmp_c[ch][s] = acc[CH_W-1:0];
			end
			cacc = '0;
			for (int k = 0; k < NUM_TAPS; k++) begin
				p = win_word.win[k][ch*CH_W +: CH_W];
				cacc = cacc + 20'($signed({1'b0, p})) *
					20'($signed(custom_kernel[k*COEF_BITS +: COEF_BITS]));
			end
			if (cacc > 20'sd255) cust_c[ch] = 8'd255;
			else if (cacc < 20'sd0) cust_c[ch] = '0;
			else cust_c[ch] = cacc[CH_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s3_v_q <= 1'b0;
		end else if (win_valid && win_ready) begin
			s3_v_q <= 1'b1;
		end else if (o_ready) begin
			s3_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (win_valid && win_ready) begin
			cmp_s3  <= cmp_c;
			cust_s3 <= cust_c;
			last_s3 <= win_word.last;
		end
	end

	// eight clamped results sum to at most 2040, so the quotient fits a channel
	always_comb begin
		logic [10:0] sum;
		for (int ch = 0; ch < NUM_CH; ch++) begin
			sum = '0;
			for (int s = 0; s < NUM_MASKS; s++) sum = sum + 11'(cmp_s3[ch][s]);
			if (kernel_mode) pix_c[ch*CH_W +: CH_W] = {3'b000, cust_s3[ch][CH_W-1:3]};
			else pix_c[ch*CH_W +: CH_W] = sum[10:3];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_v_q <= 1'b0;
		end else if (s3_v_q && o_ready) begin
			o_v_q <= 1'b1;
		end else if (out_ready) begin
			o_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s3_v_q && o_ready) begin
			pix_q  <= pix_c;
			last_q <= last_s3;
		end
	end

	assign out_valid = o_v_q;
	assign out_pix   = pix_q;
	assign out_last  = last_q;

endmodule

### rtl/core/compass_edge_convolution_3x3_unit.sv
// top level of the 3x3 compass edge convolution unit
//
// channel  direction  handshake            payload
// in       sink       in_valid/in_ready    blue_in green_in red_in drain_pad
// out      source     out_valid/out_ready  blue_out green_out red_out frame_end
// cfg      sink       cfg_wen              cfg_index cfg_data
//
// one word per cycle sustained while the output is not stalled; the dual-port line ram
// takes one read and one write-back per word, and forwarding covers a one-pixel row
// a word moves through the input stage, window, filter and output registers in turn;
// the result for a pixel follows the word that arrives row_width+1 words later
// reset clears control and counters; the line ram is not cleared, border masking hides it
// a stalled output holds the pipe; the input keeps taking words while stages are empty
module compass_edge_convolution_3x3_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [7:0]                      blue_in,
	input  logic [7:0]                      green_in,
	input  logic [7:0]                      red_in,
	input  logic                            drain_pad,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [7:0]                      blue_out,
	output logic [7:0]                      green_out,
	output logic [7:0]                      red_out,
	output logic                            frame_end,
	input  logic                            cfg_wen,
	input  logic [cecu_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cecu_pkg::KERN_W-1:0]     cfg_data
);
	import cecu_pkg::*;

	// configuration registers
	logic [DIM_W-1:0]  row_width_q;
	logic [DIM_W-1:0]  frame_height_q;
	logic              kernel_mode_q;
	logic [KERN_W-1:0] custom_kernel_q;

	geom_t     geom;
	logic      restart;
	pix_t      pix;
	logic      win_valid, win_ready;
	win_word_t win_word;
	pix_t      out_pix;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_width_q     <= DIM_W'(ROW_WIDTH_RESET);
			frame_height_q  <= DIM_W'(FRAME_HEIGHT_RESET);
			kernel_mode_q   <= 1'b0;
			custom_kernel_q <= '0;
		end else if (cfg_wen) begin
			case (cfg_reg_t'(cfg_index))
				REG_ROW_WIDTH:     row_width_q <= cfg_data[DIM_W-1:0];
				REG_FRAME_HEIGHT:  frame_height_q <= cfg_data[DIM_W-1:0];
				REG_KERNEL_MODE:   kernel_mode_q <= cfg_data[0];
				REG_CUSTOM_KERNEL: custom_kernel_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// a geometry write starts a new frame
	assign restart = cfg_wen && ((cfg_reg_t'(cfg_index) == REG_ROW_WIDTH) ||
		(cfg_reg_t'(cfg_index) == REG_FRAME_HEIGHT));

	// zero width or height act as one, oversize ones saturate
	always_comb begin
		if (row_width_q == '0) geom.width = 13'd1;
		else if (row_width_q > DIM_W'(MAX_WIDTH)) geom.width = DIM_W'(MAX_WIDTH);
		else geom.width = row_width_q;
		if (frame_height_q == '0) geom.height = 13'd1;
		else if (frame_height_q > DIM_W'(HEIGHT_LIMIT)) geom.height = DIM_W'(HEIGHT_LIMIT);
		else geom.height = frame_height_q;
	end

	// padding words enter as black pixels
	assign pix = drain_pad ? '0 : {red_in, green_in, blue_in};

	cecu_window u_window (
		.clk      (clk),
		.arst_n   (arst_n),
		.geom     (geom),
		.restart  (restart),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.pix      (pix),
		.win_valid(win_valid),
		.win_ready(win_ready),
		.win_word (win_word)
	);

	cecu_filter u_filter (
		.clk          (clk),
		.arst_n       (arst_n),
		.kernel_mode  (kernel_mode_q),
		.custom_kernel(custom_kernel_q),
		.win_valid    (win_valid),
		.win_ready    (win_ready),
		.win_word     (win_word),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_pix      (out_pix),
		.out_last     (frame_end)
	);

	assign blue_out  = out_pix[CH_W-1:0];
	assign green_out = out_pix[2*CH_W-1:CH_W];
	assign red_out   = out_pix[3*CH_W-1:2*CH_W];

`include "compass_edge_convolution_3x3_unit_assert.svh"

	// a free output register lets every stage move, so input must be open
	`CECU_ASSERT_SAME(a_ready_when_free, !out_valid || out_ready, in_ready, "input blocked with free output")
	// a window waiting on the filter keeps its word
	`CECU_ASSERT_NEXT(a_window_hold, win_valid && !win_ready, win_valid && $stable(win_word), "window word lost while stalled")

endmodule

### tb/compass_edge_convolution_3x3_unit_tb.sv
// testbench for the compass edge convolution unit: directed and random frames checked against a predictor
module compass_edge_convolution_3x3_unit_tb;
	import cecu_pkg::*;

	localparam int CYCLE_LIMIT = 600000;
	localparam int SETTLE = 12;

	typedef struct {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
		logic       frame_end;
	} pixel_out_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [7:0] blue_in = '0, green_in = '0, red_in = '0;
	logic drain_pad = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [7:0] blue_out, green_out, red_out;
	logic frame_end;
	logic cfg_wen = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [KERN_W-1:0] cfg_data = '0;

	compass_edge_convolution_3x3_unit dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state, mirrors the block's registers and line stores
	int unsigned width_reg, height_reg, col_pos, row_pos;
	logic mode_reg;
	logic [KERN_W-1:0] kernel_reg;
	logic [23:0] upper_line [MAX_WIDTH];
	logic [23:0] middle_line [MAX_WIDTH];
	logic [23:0] window [9];
	int compass_mask [8][9];

	pixel_out_t pending_pixels [$];
	int fails = 0;
	int cycles = 0;
	bit quiet = 0;	// no idling on either side while set

	task automatic report(input string what, input int got, input int want);
		$display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
		fails++;
	endtask

	function automatic int eff_width();
		if (width_reg == 0) return 1;
		if (width_reg > MAX_WIDTH) return MAX_WIDTH;
		return width_reg;
	endfunction

	function automatic int eff_height();
		if (height_reg == 0) return 1;
		if (height_reg > HEIGHT_LIMIT) return HEIGHT_LIMIT;
		return height_reg;
	endfunction

	// one channel through the selected masks: clamp each, sum, divide by 8
	function automatic logic [7:0] filter_channel(input logic [23:0] win [9], input int shift);
		int p [9];
		int acc, sum;
		sum = 0;
		for (int k = 0; k < 9; k++) p[k] = (win[k] >> shift) & 255;
		if (mode_reg) begin
			acc = 0;
			for (int k = 0; k < 9; k++) acc += int'($signed(kernel_reg[COEF_BITS*k +: COEF_BITS])) * p[k];
			sum = acc > 255 ? 255 : (acc < 0 ? 0 : acc);
		end else begin
			for (int s = 0; s < 8; s++) begin
				acc = 0;
				for (int k = 0; k < 9; k++) acc += compass_mask[s][k] * p[k];
				sum += acc > 255 ? 255 : (acc < 0 ? 0 : acc);
			end
		end
		return 8'(sum / 8);
	endfunction

	// advance the predictor by one accepted word
	task automatic predict_pixel(input logic [7:0] b, g, r_in, input logic pad);
		int w, h, c, r, orow, ocol;
		logic [23:0] pix, c0, c1;
		logic [23:0] win [9];
		logic last;
		pixel_out_t res;
		w = eff_width();
		h = eff_height();
		c = col_pos;
		r = row_pos;
		if (c >= w || r > h + 1) begin
			c = 0;
			r = 0;
		end
		pix = pad ? 24'd0 : {r_in, g, b};
		c0 = upper_line[c];
		c1 = middle_line[c];
		upper_line[c] = c1;
		middle_line[c] = pix;
		for (int i = 0; i < 3; i++) begin
			window[i*3] = window[i*3+1];
			window[i*3+1] = window[i*3+2];
		end
		window[2] = c0;
		window[5] = c1;
		window[8] = pix;
		// first row plus one pixel gives no result yet
		if (!(r >= 2 || (r == 1 && c >= 1))) begin
			if (c + 1 >= w) begin
				col_pos = 0;
				row_pos = r + 1;
			end else begin
				col_pos = c + 1;
				row_pos = r;
			end
			return;
		end
		if (c == 0) begin
			orow = r - 2;
			ocol = w - 1;
		end else begin
			orow = r - 1;
			ocol = c - 1;
		end
		win = window;
		// zero border, whatever the line stores hold
		for (int i = 0; i < 3; i++) begin
			if (ocol == 0) win[i*3] = '0;
			if (ocol == w - 1) win[i*3+2] = '0;
			if (orow == 0) win[i] = '0;
			if (orow == h - 1) win[6+i] = '0;
		end
		last = (orow == h - 1) && (ocol == w - 1);
		res.blue = filter_channel(win, 0);
		res.green = filter_channel(win, 8);
		res.red = filter_channel(win, 16);
		res.frame_end = last;
		pending_pixels.push_back(res);
		if (last) begin
			col_pos = 0;
			row_pos = 0;
		end else if (c + 1 >= w) begin
			col_pos = 0;
			row_pos = r + 1;
		end else begin
			col_pos = c + 1;
			row_pos = r;
		end
	endtask

	// offer one word, valid stays high after acceptance until the next word or a pause
	task automatic send_word(input logic [7:0] b, g, r_in, input logic pad);
		if (!quiet && $urandom_range(99) < 10) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(3, 1)) @(posedge clk);
		end
		in_valid <= 1'b1;
		blue_in <= b;
		green_in <= g;
		red_in <= r_in;
		drain_pad <= pad;
		do @(posedge clk); while (!in_ready);
		predict_pixel(b, g, r_in, pad);
	endtask

	task automatic send_random(input int pad_pct);
		send_word(8'($urandom), 8'($urandom), 8'($urandom), $urandom_range(99) < pad_pct);
	endtask

	// drop valid, wait for every expected word, then let words with no result clear the pipe
	task automatic quiesce();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [KERN_W-1:0] v);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_wen <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_ROW_WIDTH: begin
				width_reg = v[12:0];
				col_pos = 0;
				row_pos = 0;
			end
			REG_FRAME_HEIGHT: begin
				height_reg = v[12:0];
				col_pos = 0;
				row_pos = 0;
			end
			REG_KERNEL_MODE: mode_reg = v[0];
			default: kernel_reg = v;
		endcase
	endtask

	task automatic set_geometry(input int w, input int h);
		quiesce();
		write_reg(REG_ROW_WIDTH, KERN_W'(w));
		write_reg(REG_FRAME_HEIGHT, KERN_W'(h));
	endtask

	// a whole frame of random pixels plus the drain words that flush it
	task automatic send_frame(input int pad_pct);
		int n;
		n = eff_width() * eff_height();
		for (int i = 0; i < n; i++) send_random(pad_pct);
		for (int i = 0; i <= eff_width(); i++)
			send_word(8'($urandom), 8'($urandom), 8'($urandom), 1'b1);
	endtask

	// reset geometry: a partial 640-wide row gives no word, then a geometry write restarts it
	task automatic test_reset_defaults();
		for (int i = 0; i < 20; i++) send_random(5);
		set_geometry(3, 3);
		send_frame(0);
	endtask

	// extremes of the pixel values in both modes
	task automatic test_directed();
		quiet = 1;
		set_geometry(3, 3);
		for (int i = 0; i < 9; i++)
			if (i % 2) send_word(8'hff, 8'h00, 8'hff, 1'b0);
			else send_word(8'h00, 8'hff, 8'h00, 1'b0);
		for (int i = 0; i < 4; i++) send_word(8'hff, 8'hff, 8'hff, 1'b1);
		quiesce();
		write_reg(REG_KERNEL_MODE, 1);
		// all coefficients at the most positive value
		write_reg(REG_CUSTOM_KERNEL, {9{7'h3f}});
		for (int i = 0; i < 9; i++) send_word(8'hff, 8'hff, 8'hff, 1'b0);
		for (int i = 0; i < 4; i++) send_word(8'h00, 8'h00, 8'h00, 1'b1);
		quiesce();
		// most negative center, positive ring
		write_reg(REG_CUSTOM_KERNEL, {{4{7'h01}}, 7'h40, {4{7'h01}}});
		for (int i = 0; i < 9; i++) send_word(8'(i * 30), 8'hff, 8'h01, 1'b0);
		for (int i = 0; i < 4; i++) send_word(8'h00, 8'h00, 8'h00, 1'b1);
		quiesce();
		write_reg(REG_KERNEL_MODE, 0);
		quiet = 0;
	endtask

	// out-of-range geometry, and short runs into the largest geometry
	task automatic test_geometry_extremes();
		set_geometry(0, 0);
		send_frame(0);
		set_geometry(1, 1);
		send_frame(0);
		set_geometry(4096, 1);
		for (int i = 0; i < 8; i++) send_random(2);
		set_geometry(8191, 1);
		for (int i = 0; i < 8; i++) send_random(2);
		set_geometry(1, 4096);
		for (int i = 0; i < 12; i++) send_random(2);
		set_geometry(1, 8191);
		for (int i = 0; i < 12; i++) send_random(2);
		set_geometry(2, 2);
		send_frame(0);
	endtask

	// mode flips halfway through a frame while the block is idle
	task automatic test_mode_switch();
		set_geometry(4, 4);
		for (int i = 0; i < 10; i++) send_random(0);
		quiesce();
		write_reg(REG_KERNEL_MODE, 1);
		write_reg(REG_CUSTOM_KERNEL, KERN_W'({$urandom, $urandom}));
		for (int i = 0; i < 11; i++) send_random(0);
		quiesce();
		write_reg(REG_KERNEL_MODE, 0);
		send_frame(0);
	endtask

	// random small frames, random modes and kernels, some stray drain words
	task automatic test_random();
		int sent;
		sent = 0;
		while (sent < 250) begin
			set_geometry($urandom_range(8, 1), $urandom_range(6, 1));
			write_reg(REG_KERNEL_MODE, $urandom_range(1));
			write_reg(REG_CUSTOM_KERNEL, KERN_W'({$urandom, $urandom}));
			quiet = ($urandom_range(4) == 0);
			send_frame($urandom_range(1) ? 0 : 10);
			sent += eff_width() * eff_height() + eff_width() + 1;
			// occasionally a broken frame cut short by a geometry write
			if ($urandom_range(5) == 0)
				for (int i = 0; i < eff_width() + 2; i++) send_random(10);
			quiet = 0;
		end
	endtask

	// output side: random stalls and in-order checking
	always @(posedge clk) begin
		pixel_out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_pixels.size() == 0) begin
				report("unexpected word", 1, 0);
			end else begin
				want = pending_pixels.pop_front();
				if (blue_out !== want.blue) report("blue_out", blue_out, want.blue);
				if (green_out !== want.green) report("green_out", green_out, want.green);
				if (red_out !== want.red) report("red_out", red_out, want.red);
				if (frame_end !== want.frame_end) report("frame_end", frame_end, want.frame_end);
			end
		end
		out_ready <= arst_n && (quiet || $urandom_range(99) >= 10);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		for (int s = 0; s < 8; s++) begin
			automatic int ring_pos [8] = '{0, 1, 2, 5, 8, 7, 6, 3};
			automatic int base_ring [8] = '{-1, 0, 1, 2, 1, 0, -1, -2};
			compass_mask[s][4] = 0;
			for (int i = 0; i < 8; i++) compass_mask[s][ring_pos[i]] = base_ring[(i + s) & 7];
		end
		width_reg = ROW_WIDTH_RESET;
		height_reg = FRAME_HEIGHT_RESET;
		mode_reg = 1'b0;
		kernel_reg = '0;
		col_pos = 0;
		row_pos = 0;
		for (int i = 0; i < MAX_WIDTH; i++) begin
			upper_line[i] = '0;
			middle_line[i] = '0;
		end
		for (int i = 0; i < 9; i++) window[i] = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_directed();
		test_geometry_extremes();
		test_mode_switch();
		test_random();
		quiesce();
		if (fails == 0) $display("SUCCESS");
		else $display("FAILURE");
		$finish;
	end
endmodule

### files.f
+incdir+rtl/core
rtl/core/cecu_pkg.sv
rtl/core/cecu_ram.sv
rtl/core/cecu_window.sv
rtl/core/cecu_filter.sv
rtl/core/compass_edge_convolution_3x3_unit.sv
tb/compass_edge_convolution_3x3_unit_tb.sv
